@@ design/emfd_pkg.sv @@
// shared constants and types of the energy meter frame decoder
// no dependencies
package emfd_pkg;

  localparam int FRAME_LEN = 24;
  localparam int CNT_W = 5;
  localparam int BYTE_W = 8;
  localparam int COEF_W = 16;
  localparam int REG_W = 24;
  localparam int PROD_V_W = REG_W + COEF_W;
  localparam int PCOEF_W = REG_W + 2 * COEF_W;
  localparam int NUM_W = 80;
  localparam int DIV_W = 58;
  localparam int OUT_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h5A;
  localparam logic [BYTE_W-1:0] NO_CORRECTION = 8'hAA;
  localparam logic [BYTE_W-1:0] V_OVF_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] C_OVF_MASK = 8'hF4;
  localparam logic [BYTE_W-1:0] P_OVF_MASK = 8'hF2;
  localparam int UPDATE_BIT = 7;
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd256;
  localparam logic [DIV_W-1:0] PULSE_DIV = 58'(64'd3600000000000 * 64'd65536);

  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_COEF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_COEF = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_HDR  = 2'd1,
    STATUS_BAD_SUM  = 2'd2,
    STATUS_NO_CORR  = 2'd3
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [REG_W-1:0] vp;
    logic [REG_W-1:0] v;
    logic [REG_W-1:0] cp;
    logic [REG_W-1:0] c;
    logic [REG_W-1:0] pp;
    logic [REG_W-1:0] p;
    logic [REG_W-1:0] pf;
  } frame_t;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] voltage;
    logic [OUT_W-1:0] current;
    logic [OUT_W-1:0] active_power;
    logic [OUT_W-1:0] energy;
  } result_t;

endpackage

@@ design/emfd_in_if.sv @@
// input channel: one frame byte per word
// depends on emfd_pkg
interface emfd_in_if;
  logic                         valid;
  logic                         ready;
  logic [emfd_pkg::BYTE_W-1:0]  byte_in;
  logic                         frame_start;
  modport source (output valid, byte_in, frame_start, input ready);
  modport sink (input valid, byte_in, frame_start, output ready);
endinterface

@@ design/emfd_out_if.sv @@
// output channel: one decoded frame per word
// depends on emfd_pkg
interface emfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [emfd_pkg::OUT_W-1:0]  voltage;
  logic [emfd_pkg::OUT_W-1:0]  current;
  logic [emfd_pkg::OUT_W-1:0]  active_power;
  logic [emfd_pkg::OUT_W-1:0]  energy;
  modport source (output valid, status, voltage, current, active_power, energy, input ready);
  modport sink (input valid, status, voltage, current, active_power, energy, output ready);
endinterface

@@ design/emfd_collect.sv @@
// byte collector: shift line of frame bytes, checksum, checks, pulse wrap counter
// depends on emfd_pkg
module emfd_collect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [emfd_pkg::BYTE_W-1:0] byte_in,
  input  logic                        frame_start,
  output logic                        go,
  output emfd_pkg::frame_t            frame
);

  logic [emfd_pkg::FRAME_LEN-2:0][emfd_pkg::BYTE_W-1:0] sr;
  logic [emfd_pkg::CNT_W-1:0]  cnt;
  logic [emfd_pkg::BYTE_W-1:0] sum;
  logic [emfd_pkg::BYTE_W-1:0] wraps;
  logic                        last_bit;

  logic                        active;
  logic                        complete;
  logic                        add_byte;
  logic [emfd_pkg::CNT_W-1:0]  cnt_next;
  logic [emfd_pkg::BYTE_W-1:0] b0;
  logic [emfd_pkg::BYTE_W-1:0] wraps_next;
  logic                        upd;
  emfd_pkg::status_t           status;
  emfd_pkg::frame_t            frame_next;

  always_comb begin
    active = accept && (frame_start || cnt != emfd_pkg::CNT_W'(emfd_pkg::FRAME_LEN));
    cnt_next = frame_start ? emfd_pkg::CNT_W'(1) : cnt + 1'b1;
    add_byte = !frame_start && cnt >= emfd_pkg::CNT_W'(2) && cnt <= emfd_pkg::CNT_W'(22);
    complete = active && cnt_next == emfd_pkg::CNT_W'(emfd_pkg::FRAME_LEN);
    b0 = sr[22];
    if (sr[21] != emfd_pkg::HEADER_BYTE) begin
      status = emfd_pkg::STATUS_BAD_HDR;
    end else if (sum != byte_in) begin
      status = emfd_pkg::STATUS_BAD_SUM;
    end else if (b0 == emfd_pkg::NO_CORRECTION) begin
      status = emfd_pkg::STATUS_NO_CORR;
    end else begin
      status = emfd_pkg::STATUS_OK;
    end
    upd = sr[2][emfd_pkg::UPDATE_BIT];
    wraps_next = (upd != last_bit) ? wraps + 1'b1 : wraps;
    frame_next.status = status;
    frame_next.vp = sr[20:18];
    frame_next.v = ((b0 & emfd_pkg::V_OVF_MASK) == emfd_pkg::V_OVF_MASK) ? '0 : sr[17:15];
    frame_next.cp = sr[14:12];
    frame_next.c = ((b0 & emfd_pkg::C_OVF_MASK) == emfd_pkg::C_OVF_MASK) ? '0 : sr[11:9];
    frame_next.pp = sr[8:6];
    frame_next.p = ((b0 & emfd_pkg::P_OVF_MASK) == emfd_pkg::P_OVF_MASK) ? '0 : sr[5:3];
    frame_next.pf = {wraps_next, sr[1], sr[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= emfd_pkg::CNT_W'(emfd_pkg::FRAME_LEN);
      sum <= '0;
      wraps <= '0;
      last_bit <= 1'b0;
      go <= 1'b0;
    end else begin
      go <= complete;
      if (active) begin
        cnt <= cnt_next;
        if (frame_start) begin
          sum <= '0;
        end else if (add_byte) begin
          sum <= sum + byte_in;
        end
      end
      if (complete && status == emfd_pkg::STATUS_OK) begin
        wraps <= wraps_next;
        last_bit <= upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      sr <= {sr[emfd_pkg::FRAME_LEN-3:0], byte_in};
    end
    if (complete) begin
      frame <= frame_next;
    end
  end

endmodule

@@ design/emfd_arith.sv @@
// arithmetic sequencer: coefficient products, serial multiplier, bit-serial divider
// depends on emfd_pkg
module emfd_arith #(
  parameter int FRAC_BITS = emfd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  emfd_pkg::frame_t            frame,
  input  logic [emfd_pkg::COEF_W-1:0] vc,
  input  logic [emfd_pkg::COEF_W-1:0] cc,
  output logic                        idle,
  output logic                        done,
  input  logic                        ack,
  output emfd_pkg::result_t           result
);

  localparam int CW = $clog2(emfd_pkg::NUM_W + FRAC_BITS + 1);
  localparam logic [CW-1:0] IT_V = CW'(emfd_pkg::PROD_V_W + FRAC_BITS);
  localparam logic [CW-1:0] IT_C = CW'(emfd_pkg::REG_W + FRAC_BITS);
  localparam logic [CW-1:0] IT_P = CW'(emfd_pkg::PCOEF_W + FRAC_BITS);
  localparam logic [CW-1:0] IT_E = CW'(emfd_pkg::NUM_W + FRAC_BITS);
  localparam int MC_W = $clog2(emfd_pkg::REG_W + 1);

  localparam logic [1:0] JOB_V = 2'd0;
  localparam logic [1:0] JOB_C = 2'd1;
  localparam logic [1:0] JOB_P = 2'd2;
  localparam logic [1:0] JOB_E = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PC1   = 7'b0000010,
    ST_PC2   = 7'b0000100,
    ST_SETUP = 7'b0001000,
    ST_EMUL  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                           state;
  emfd_pkg::frame_t                 fr;
  logic [emfd_pkg::PROD_V_W-1:0]    m1;
  logic [emfd_pkg::PCOEF_W-1:0]     pcoef;
  logic [1:0]                       job;
  logic [emfd_pkg::NUM_W-1:0]       num;
  logic [emfd_pkg::DIV_W-1:0]       dvs;
  logic [emfd_pkg::DIV_W-1:0]       rem;
  logic [emfd_pkg::OUT_W-1:0]       q;
  logic                             sat;
  logic [CW-1:0]                    cnt;
  logic [emfd_pkg::REG_W-1:0]       mb;
  logic [MC_W-1:0]                  mcnt;

  logic [emfd_pkg::PROD_V_W-1:0]    vprod;
  logic [emfd_pkg::DIV_W:0]         remsh;
  logic [emfd_pkg::DIV_W:0]         diff;
  logic                             ge;
  logic [emfd_pkg::DIV_W-1:0]       rem_next;
  logic [emfd_pkg::OUT_W-1:0]       q_next;
  logic                             sat_next;
  logic [emfd_pkg::OUT_W-1:0]       qval;
  logic                             dv_zero;

  always_comb begin
    vprod = emfd_pkg::PROD_V_W'(fr.vp * vc);
    remsh = {rem, num[emfd_pkg::NUM_W-1]};
    diff = remsh - {1'b0, dvs};
    ge = remsh >= {1'b0, dvs};
    rem_next = ge ? diff[emfd_pkg::DIV_W-1:0] : remsh[emfd_pkg::DIV_W-1:0];
    q_next = {q[emfd_pkg::OUT_W-2:0], ge};
    sat_next = sat | q[emfd_pkg::OUT_W-1];
    qval = sat_next ? '1 : q_next;
    case (job)
      JOB_V:   dv_zero = fr.v == '0;
      JOB_C:   dv_zero = fr.c == '0;
      JOB_P:   dv_zero = fr.p == '0;
      default: dv_zero = 1'b0;
    endcase
  end

  assign idle = state == ST_IDLE;
  assign done = state == ST_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job <= JOB_V;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            job <= JOB_V;
            state <= (frame.status == emfd_pkg::STATUS_OK) ? ST_PC1 : ST_DONE;
          end
        end
        ST_PC1: begin
          state <= ST_PC2;
        end
        ST_PC2: begin
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          if (job == JOB_E) begin
            state <= ST_EMUL;
          end else if (dv_zero) begin
            job <= job + 1'b1;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_EMUL: begin
          if (mcnt == MC_W'(1)) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CW'(1)) begin
            if (job == JOB_E) begin
              state <= ST_DONE;
            end else begin
              job <= job + 1'b1;
              state <= ST_SETUP;
            end
          end
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (go) begin
          fr <= frame;
          result <= '{status: frame.status, voltage: '0, current: '0,
                      active_power: '0, energy: '0};
        end
      end
      ST_PC1: begin
        m1 <= emfd_pkg::PROD_V_W'(fr.pp * vc);
      end
      ST_PC2: begin
        pcoef <= emfd_pkg::PCOEF_W'(m1 * cc);
      end
      ST_SETUP: begin
        rem <= '0;
        q <= '0;
        sat <= 1'b0;
        case (job)
          JOB_V: begin
            num <= {vprod, (emfd_pkg::NUM_W - emfd_pkg::PROD_V_W)'(0)};
            dvs <= emfd_pkg::DIV_W'({fr.v, 8'd0});
            cnt <= IT_V;
          end
          JOB_C: begin
            num <= {fr.cp, (emfd_pkg::NUM_W - emfd_pkg::REG_W)'(0)};
            dvs <= emfd_pkg::DIV_W'(fr.c);
            cnt <= IT_C;
          end
          JOB_P: begin
            num <= {pcoef, (emfd_pkg::NUM_W - emfd_pkg::PCOEF_W)'(0)};
            dvs <= emfd_pkg::DIV_W'({fr.p, 16'd0});
            cnt <= IT_P;
          end
          default: begin
            num <= '0;
            mb <= fr.pf;
            mcnt <= MC_W'(emfd_pkg::REG_W);
            dvs <= emfd_pkg::PULSE_DIV;
            cnt <= IT_E;
          end
        endcase
      end
      ST_EMUL: begin
        num <= {num[emfd_pkg::NUM_W-2:0], 1'b0}
             + (mb[emfd_pkg::REG_W-1] ? emfd_pkg::NUM_W'(pcoef) : '0);
        mb <= {mb[emfd_pkg::REG_W-2:0], 1'b0};
        mcnt <= mcnt - 1'b1;
      end
      ST_DIV: begin
        num <= {num[emfd_pkg::NUM_W-2:0], 1'b0};
        rem <= rem_next;
        q <= q_next;
        sat <= sat_next;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          case (job)
            JOB_V:   result.voltage <= qval;
            JOB_C:   result.current <= qval;
            JOB_P:   result.active_power <= qval;
            default: result.energy <= qval;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/energy_meter_frame_decoder_top.sv @@
// top level of the energy meter frame decoder: coefficient registers and output register
// depends on emfd_pkg, emfd_in_if, emfd_out_if, emfd_collect, emfd_arith
//
// channel   dir  word
// bytes     in   byte_in, frame_start
// results   out  status, voltage, current, active_power, energy
// cfg_*     in   write enable, register index, 16-bit data
//
// a byte is taken each cycle while the sequencer is idle and go is low; one result per
// 24-byte frame. a good frame passes two coefficient product steps, then a setup and a
// bit-serial division each for voltage, current and active power (skipped on a zero
// divisor), then a setup, the serial pulse multiplier and the energy division; a
// rejected frame goes straight to the done state. bytes stall while a frame is being
// worked and while a finished result waits behind a full output register
// synchronous reset, no clearing pass
module energy_meter_frame_decoder_top #(
  parameter int FRAC_BITS = emfd_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  emfd_in_if.sink                        bytes,
  emfd_out_if.source                     results,
  input  logic                           cfg_we,
  input  logic [emfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [emfd_pkg::COEF_W-1:0]    cfg_data
);

  logic [emfd_pkg::COEF_W-1:0] vc;
  logic [emfd_pkg::COEF_W-1:0] cc;
  logic                        go;
  emfd_pkg::frame_t            frame;
  logic                        idle;
  logic                        done;
  logic                        load;
  emfd_pkg::result_t           res;
  emfd_pkg::result_t           out_reg;
  logic                        out_valid;

  assign bytes.ready = idle && !go;
  assign load = done && (!out_valid || results.ready);

  emfd_collect u_collect (
    .clk         (clk),
    .rst         (rst),
    .accept      (bytes.valid && bytes.ready),
    .byte_in     (bytes.byte_in),
    .frame_start (bytes.frame_start),
    .go          (go),
    .frame       (frame)
  );

  emfd_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .frame  (frame),
    .vc     (vc),
    .cc     (cc),
    .idle   (idle),
    .done   (done),
    .ack    (load),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= emfd_pkg::COEF_RESET;
      cc <= emfd_pkg::COEF_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          emfd_pkg::REG_VOLTAGE_COEF: vc <= cfg_data;
          emfd_pkg::REG_CURRENT_COEF: cc <= cfg_data;
          default: begin
          end
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.status = out_reg.status;
  assign results.voltage = out_reg.voltage;
  assign results.current = out_reg.current;
  assign results.active_power = out_reg.active_power;
  assign results.energy = out_reg.energy;

endmodule

@@ test/energy_meter_frame_decoder_top_tb.sv @@
// testbench for energy_meter_frame_decoder_top: sends frames and noise as byte words,
// predicts each decoded frame with its own fixed-point math and checks every result word
// depends on emfd_pkg, emfd_in_if, emfd_out_if and the decoder rtl
`timescale 1ns / 100ps

class frame_scoreboard;
  logic [7:0]  frame_buf [24];
  int          byte_idx;
  logic [7:0]  sum_acc;
  logic [7:0]  wraps;
  logic        last_bit;
  logic [15:0] vcoef;
  logic [15:0] ccoef;
  emfd_pkg::result_t expected_q[$];
  int errors;
  int checked;
  int by_status [4];

  function new();
    byte_idx = 24;
    sum_acc = '0;
    wraps = '0;
    last_bit = 1'b0;
    vcoef = emfd_pkg::COEF_RESET;
    ccoef = emfd_pkg::COEF_RESET;
    errors = 0;
    checked = 0;
    for (int i = 0; i < 4; i++) by_status[i] = 0;
    for (int i = 0; i < 24; i++) frame_buf[i] = '0;
  endfunction

  function automatic logic [31:0] ratio_sat(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == 0) return '0;
    q = num / den;
    if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic [23:0] pair_at(int pos);
    return {frame_buf[pos], frame_buf[pos+1], frame_buf[pos+2]};
  endfunction

  function automatic void note_byte(logic [7:0] b, logic start);
    emfd_pkg::result_t r;
    logic [7:0] b0;
    logic [127:0] vp, v, cp, c, pp, p, pf, pcoef;
    logic upd;
    if (start) begin
      byte_idx = 0;
      sum_acc = '0;
    end else if (byte_idx >= 24) begin
      return;
    end
    frame_buf[byte_idx] = b;
    if (byte_idx >= 2 && byte_idx <= 22) sum_acc = sum_acc + b;
    byte_idx++;
    if (byte_idx < 24) return;
    r = '0;
    b0 = frame_buf[0];
    if (frame_buf[1] != emfd_pkg::HEADER_BYTE) begin
      r.status = emfd_pkg::STATUS_BAD_HDR;
    end else if (sum_acc != frame_buf[23]) begin
      r.status = emfd_pkg::STATUS_BAD_SUM;
    end else if (b0 == emfd_pkg::NO_CORRECTION) begin
      r.status = emfd_pkg::STATUS_NO_CORR;
    end else begin
      r.status = emfd_pkg::STATUS_OK;
      vp = pair_at(2);
      v = ((b0 & emfd_pkg::V_OVF_MASK) != emfd_pkg::V_OVF_MASK) ? pair_at(5) : 0;
      cp = pair_at(8);
      c = ((b0 & emfd_pkg::C_OVF_MASK) != emfd_pkg::C_OVF_MASK) ? pair_at(11) : 0;
      pp = pair_at(14);
      p = ((b0 & emfd_pkg::P_OVF_MASK) != emfd_pkg::P_OVF_MASK) ? pair_at(17) : 0;
      pcoef = pp * vcoef * ccoef;
      upd = frame_buf[20][emfd_pkg::UPDATE_BIT];
      if (upd != last_bit) begin
        wraps = wraps + 8'd1;
        last_bit = upd;
      end
      pf = {wraps, frame_buf[21], frame_buf[22]};
      r.voltage = ratio_sat((vp * vcoef) << 16, v << 8);
      r.current = ratio_sat(cp << 16, c);
      r.active_power = ratio_sat(pcoef << 16, p << 16);
      r.energy = ratio_sat((pf << 16) * pcoef, 128'd3600000000000 << 16);
    end
    expected_q.push_back(r);
  endfunction

  function automatic void check_result(emfd_pkg::result_t got);
    emfd_pkg::result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result word with nothing expected: status %0d", got.status);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    checked++;
    by_status[exp_r.status]++;
    if (got.status != exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.voltage != exp_r.voltage) begin
      $error("voltage: expected %h, got %h", exp_r.voltage, got.voltage);
      errors++;
    end
    if (got.current != exp_r.current) begin
      $error("current: expected %h, got %h", exp_r.current, got.current);
      errors++;
    end
    if (got.active_power != exp_r.active_power) begin
      $error("active_power: expected %h, got %h", exp_r.active_power, got.active_power);
      errors++;
    end
    if (got.energy != exp_r.energy) begin
      $error("energy: expected %h, got %h", exp_r.energy, got.energy);
      errors++;
    end
  endfunction
endclass

module energy_meter_frame_decoder_top_tb;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 400;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [emfd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [emfd_pkg::COEF_W-1:0] cfg_data;

  emfd_in_if bytes ();
  emfd_out_if results ();

  energy_meter_frame_decoder_top dut (
    .clk(clk), .rst(rst), .bytes(bytes), .results(results),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  frame_scoreboard sb;
  int burst_left = 0;
  int no_gaps = 0;
  int rx_hold = 0;
  int rx_busy = 1;
  int sent_bytes = 0;
  int idle_cycles = 0;

  // scoreboard taps on accepted words
  always @(posedge clk) begin
    if (!rst && bytes.valid && bytes.ready) sb.note_byte(bytes.byte_in, bytes.frame_start);
    if (!rst && results.valid && results.ready)
      sb.check_result({emfd_pkg::status_t'(results.status), results.voltage,
                       results.current, results.active_power, results.energy});
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      results.ready <= 1'b0;
    end else if (rx_busy != 0) begin
      results.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      results.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes.valid && bytes.ready) || (results.valid && results.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps != 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        bytes.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    bytes.valid <= 1'b1;
    bytes.byte_in <= b;
    bytes.frame_start <= start;
    do @(posedge clk); while (!bytes.ready);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] b0, input bit hdr_ok, input bit sum_ok,
                            input int fill, input int cut);
    logic [7:0] fr [24];
    logic [7:0] s;
    int n;
    fr[0] = b0;
    fr[1] = hdr_ok ? emfd_pkg::HEADER_BYTE : 8'($urandom_range(0, 255));
    if (!hdr_ok && fr[1] == emfd_pkg::HEADER_BYTE) fr[1] = 8'h5B;
    for (int i = 2; i < 23; i++) begin
      case (fill)
        1: fr[i] = 8'hFF;
        2: fr[i] = (i >= 5 && i <= 7) || (i >= 11 && i <= 13) || (i >= 17 && i <= 19) ?
                   8'h00 : 8'($urandom_range(0, 255));
        3: fr[i] = (i == 5 || i == 6 || i == 11 || i == 12 || i == 17 || i == 18) ?
                   8'h00 : 8'($urandom_range(0, 255));
        4: fr[i] = 8'h00;
        default: fr[i] = 8'($urandom_range(0, 255));
      endcase
    end
    if (fill != 1 && fill != 4) fr[20][7] = 1'($urandom_range(0, 1));
    s = '0;
    for (int i = 2; i < 23; i++) s = s + fr[i];
    fr[23] = sum_ok ? s : s + 8'($urandom_range(1, 255));
    n = (cut > 0) ? cut : 24;
    for (int i = 0; i < n; i++) send_byte(fr[i], i == 0);
  endtask

  task automatic wait_drain();
    bytes.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_coefs(input logic [15:0] vc, input logic [15:0] cc);
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= emfd_pkg::REG_VOLTAGE_COEF;
    cfg_data <= vc;
    @(posedge clk);
    cfg_index <= emfd_pkg::REG_CURRENT_COEF;
    cfg_data <= cc;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.vcoef = vc;
    sb.ccoef = cc;
  endtask

  function automatic logic [7:0] pick_b0();
    case ($urandom_range(0, 9))
      0: return emfd_pkg::NO_CORRECTION;
      1: return emfd_pkg::V_OVF_MASK | 8'($urandom_range(0, 255));
      2: return emfd_pkg::C_OVF_MASK | 8'($urandom_range(0, 255));
      3: return emfd_pkg::P_OVF_MASK | 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_frames(input int n_bytes, input bit squeeze);
    int start_cnt;
    int r;
    start_cnt = sent_bytes;
    if (squeeze) rx_hold = 3000;
    while (sent_bytes - start_cnt < n_bytes) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (r == 1) begin
        send_frame(pick_b0(), 1'b1, 1'b1, 0, $urandom_range(1, 23));
      end else begin
        send_frame(pick_b0(), $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0, 0);
      end
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    bytes.valid <= 1'b0;
    bytes.byte_in <= '0;
    bytes.frame_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle noise, each status, masks, zero divisors, restart, pulse flips
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_frame(8'h00, 1'b1, 1'b1, 0, 0);
    send_frame(8'h00, 1'b0, 1'b1, 0, 0);
    send_frame(8'h00, 1'b1, 1'b0, 0, 0);
    send_frame(emfd_pkg::NO_CORRECTION, 1'b1, 1'b1, 0, 0);
    send_frame(8'hFE, 1'b1, 1'b1, 0, 0);
    send_frame(8'h01, 1'b1, 1'b1, 2, 0);
    send_frame(8'h00, 1'b1, 1'b1, 3, 0);
    send_frame(8'h00, 1'b1, 1'b1, 0, 10);
    send_frame(8'h7F, 1'b1, 1'b1, 1, 0);
    send_frame(8'h00, 1'b1, 1'b1, 4, 0);
    wait_drain();

    set_coefs(16'd1, 16'd1);
    random_frames(150, 1'b0);
    set_coefs(16'hFFFF, 16'hFFFF);
    send_frame(8'h00, 1'b1, 1'b1, 1, 0);
    random_frames(150, 1'b1);
    set_coefs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    no_gaps = 1;
    rx_busy = 0;
    random_frames(150, 1'b0);
    no_gaps = 0;
    rx_busy = 1;
    set_coefs(16'hFFFF, 16'd1);
    random_frames(150, 1'b0);
    set_coefs(emfd_pkg::COEF_RESET, emfd_pkg::COEF_RESET);
    random_frames(150, 1'b0);

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d bytes, %0d frames: %0d good, %0d bad header, %0d bad sum, %0d no corr",
             sent_bytes, sb.checked, sb.by_status[0], sb.by_status[1], sb.by_status[2],
             sb.by_status[3]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
